// File: src/psl_pkg.sv
// Shared types and constants for the sorted priority list with key drain.
// No dependencies; used by psl_cell and the top level.
package psl_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int ID_W       = 16;
    localparam int DEST_W     = 3;
    localparam int SUB_W      = 2;
    localparam int STATUS_W   = 2;

    typedef enum logic [0:0] {
        REQ_INSERT = 1'b0,
        REQ_DRAIN  = 1'b1
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_DRAINED  = 2'd2,
        STAT_NO_MATCH = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_MARK,
        CELL_ROTATE
    } cell_op_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic [SUB_W-1:0]  sub;
        logic [DEST_W-1:0] dest;
        logic              urgent;
        logic [ID_W-1:0]   id;
    } entry_t;

    // valid cells form a prefix; mark flags entries not yet visited by a drain
    typedef struct packed {
        logic   valid;
        logic   mark;
        entry_t ent;
    } cell_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        cell_op_t op;
        entry_t   new_ent;
        entry_t   head_ent;
        logic     head_keep;
    } cell_ctl_t;

    localparam cell_t CELL_EMPTY = '{valid: 1'b0, mark: 1'b0, ent: '0};

    // true when entry a sorts strictly ahead of entry b
    function automatic logic goes_before(entry_t a, entry_t b);
        logic r;
        if (a.urgent != b.urgent) begin
            r = a.urgent;
        end else begin
            r = (a.id < b.id);
        end
        return r;
    endfunction

endpackage

// File: src/psl_cell.sv
// One cell of the sorted list chain: holds one entry with valid and mark bits.
// Depends on psl_pkg. Instantiated in a row by the top level.
module psl_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  psl_pkg::cell_ctl_t ctl,
    input  psl_pkg::cell_t    left_q,
    input  logic              left_shift,
    input  psl_pkg::cell_t    right_q,
    output psl_pkg::cell_t    cell_q,
    output logic              shift
);

    psl_pkg::cell_t cell_reg;
    psl_pkg::cell_t cell_next;
    logic           is_last;

    // this cell moves back on insert: free, or the new entry sorts ahead of it
    assign shift   = !cell_reg.valid || psl_pkg::goes_before(ctl.new_ent, cell_reg.ent);
    assign is_last = cell_reg.valid && !right_q.valid;

    always_comb begin
        cell_next = cell_reg;
        unique case (ctl.op)
            psl_pkg::CELL_HOLD: begin
                cell_next = cell_reg;
            end
            psl_pkg::CELL_INSERT: begin
                if (shift) begin
                    if (left_shift) begin
                        cell_next = left_q;
                    end else begin
                        cell_next.valid = 1'b1;
                        cell_next.ent   = ctl.new_ent;
                    end
                    cell_next.mark = 1'b0;
                end
            end
            psl_pkg::CELL_MARK: begin
                cell_next.mark = cell_reg.valid;
            end
            psl_pkg::CELL_ROTATE: begin
                // head leaves; kept head goes to the tail slot, unmarked
                if (is_last) begin
                    cell_next.valid = ctl.head_keep;
                    cell_next.mark  = 1'b0;
                    cell_next.ent   = ctl.head_ent;
                end else begin
                    cell_next = right_q;
                end
            end
            default: begin
                cell_next = cell_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
            cell_reg.mark  <= 1'b0;
        end else begin
            cell_reg.valid <= cell_next.valid;
            cell_reg.mark  <= cell_next.mark;
        end
        cell_reg.ent <= cell_next.ent;
    end

    assign cell_q = cell_reg;

endmodule

// File: src/priority_sorted_list_with_key_drain_top.sv
// Top level of the sorted priority list with key drain: controller and cell chain.
// Depends on psl_pkg and psl_cell.
//
// Usage: one request beat enters on the s_ channel (valid/ready). An insert
// (s_req_type 0) places the entry in order: urgent class first, then by
// ascending ID, later inserts behind equal keys. It answers one beat on the
// m_ channel: inserted, or full when every cell holds an entry.
// A drain (s_req_type 1) removes all entries whose destination equals
// s_dest_code and sends them in list order, the final beat with m_last set;
// a drain that matches nothing answers one no-match beat.
// Timing: an insert's result appears the cycle after acceptance. A drain
// rotates the chain once per cycle through every entry present, except
// while a held match waits for the output register to be free. s_ready
// is high only while no drain is running and the output register can
// take a beat.
// Reset empties the list. When m_ready is low the result beat holds and the
// block stops at the next point where it needs the output register.
module priority_sorted_list_with_key_drain_top #(
    parameter int LIST_DEPTH = psl_pkg::LIST_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_req_type,
    input  logic [psl_pkg::ID_W-1:0]      s_item_id,
    input  logic                          s_urgent,
    input  logic [psl_pkg::DEST_W-1:0]    s_dest_code,
    input  logic [psl_pkg::SUB_W-1:0]     s_sub_code,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [psl_pkg::STATUS_W-1:0]  m_status,
    output logic [psl_pkg::ID_W-1:0]      m_out_id,
    output logic                          m_out_urgent,
    output logic [psl_pkg::DEST_W-1:0]    m_out_dest,
    output logic [psl_pkg::SUB_W-1:0]     m_out_sub,
    output logic                          m_last
);

    psl_pkg::cell_t     cell_q [LIST_DEPTH];
    logic               shift  [LIST_DEPTH];
    psl_pkg::cell_ctl_t ctl;

    psl_pkg::state_t    state_reg, state_next;
    logic [psl_pkg::DEST_W-1:0] key_reg, key_next;
    logic               pend_valid_reg, pend_valid_next;
    psl_pkg::entry_t    pend_ent_reg, pend_ent_next;

    logic               m_valid_reg;
    psl_pkg::status_t   status_reg, status_next;
    psl_pkg::entry_t    out_ent_reg, out_ent_next;
    logic               last_reg, last_next;
    logic               load;

    psl_pkg::cell_t     head;
    logic               head_match;
    logic               full;
    logic               out_free;
    logic               accept;

    genvar gi;
    generate
        for (gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
            psl_pkg::cell_t left_q;
            psl_pkg::cell_t right_q;
            logic           left_shift;
            if (gi == 0) begin : g_first
                assign left_q     = psl_pkg::CELL_EMPTY;
                assign left_shift = 1'b0;
            end else begin : g_mid
                assign left_q     = cell_q[gi-1];
                assign left_shift = shift[gi-1];
            end
            if (gi == LIST_DEPTH - 1) begin : g_tail
                assign right_q = psl_pkg::CELL_EMPTY;
            end else begin : g_body
                assign right_q = cell_q[gi+1];
            end
            psl_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctl        (ctl),
                .left_q     (left_q),
                .left_shift (left_shift),
                .right_q    (right_q),
                .cell_q     (cell_q[gi]),
                .shift      (shift[gi])
            );
        end
    endgenerate

    assign head       = cell_q[0];
    assign head_match = (head.ent.dest == key_reg);
    assign full       = cell_q[LIST_DEPTH-1].valid;
    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = (state_reg == psl_pkg::ST_IDLE) && out_free;
    assign accept     = s_valid && s_ready;

    always_comb begin
        state_next       = state_reg;
        key_next         = key_reg;
        pend_valid_next  = pend_valid_reg;
        pend_ent_next    = pend_ent_reg;
        ctl.op           = psl_pkg::CELL_HOLD;
        ctl.new_ent.id     = s_item_id;
        ctl.new_ent.urgent = s_urgent;
        ctl.new_ent.dest   = s_dest_code;
        ctl.new_ent.sub    = s_sub_code;
        ctl.head_ent     = head.ent;
        ctl.head_keep    = !head_match;
        load             = 1'b0;
        status_next      = psl_pkg::STAT_INSERTED;
        out_ent_next     = '0;
        last_next        = 1'b1;

        unique case (state_reg)
            psl_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_req_type == psl_pkg::REQ_INSERT) begin
                        load = 1'b1;
                        if (full) begin
                            status_next = psl_pkg::STAT_FULL;
                        end else begin
                            ctl.op = psl_pkg::CELL_INSERT;
                        end
                    end else begin
                        ctl.op          = psl_pkg::CELL_MARK;
                        key_next        = s_dest_code;
                        pend_valid_next = 1'b0;
                        state_next      = psl_pkg::ST_DRAIN;
                    end
                end
            end
            psl_pkg::ST_DRAIN: begin
                if (head.mark) begin
                    // one match held back so the final beat can carry last
                    if (head_match) begin
                        if (!pend_valid_reg) begin
                            ctl.op          = psl_pkg::CELL_ROTATE;
                            pend_valid_next = 1'b1;
                            pend_ent_next   = head.ent;
                        end else if (out_free) begin
                            ctl.op        = psl_pkg::CELL_ROTATE;
                            load          = 1'b1;
                            status_next   = psl_pkg::STAT_DRAINED;
                            out_ent_next  = pend_ent_reg;
                            last_next     = 1'b0;
                            pend_ent_next = head.ent;
                        end
                    end else begin
                        ctl.op = psl_pkg::CELL_ROTATE;
                    end
                end else if (out_free) begin
                    load       = 1'b1;
                    state_next = psl_pkg::ST_IDLE;
                    if (pend_valid_reg) begin
                        status_next  = psl_pkg::STAT_DRAINED;
                        out_ent_next = pend_ent_reg;
                    end else begin
                        status_next = psl_pkg::STAT_NO_MATCH;
                    end
                    pend_valid_next = 1'b0;
                end
            end
            default: begin
                state_next = psl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= psl_pkg::ST_IDLE;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        key_reg      <= key_next;
        pend_ent_reg <= pend_ent_next;
        if (load) begin
            status_reg  <= status_next;
            out_ent_reg <= out_ent_next;
            last_reg    <= last_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_out_id     = out_ent_reg.id;
    assign m_out_urgent = out_ent_reg.urgent;
    assign m_out_dest   = out_ent_reg.dest;
    assign m_out_sub    = out_ent_reg.sub;
    assign m_last       = last_reg;

endmodule
